>>> src/ript_pkg.sv
package ript_pkg;

	localparam int HIST_DEPTH = 3;
	localparam int WIDTH_W    = 16;
	localparam int COUNT_W    = 16;
	localparam int TURN_W     = 15;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_MIN_WIDTH    = 2'd0;
	localparam logic [1:0] REG_INDEX_MARGIN = 2'd1;
	localparam logic [1:0] REG_PULSES_TURN  = 2'd2;

	localparam logic [TURN_W-1:0] PULSES_TURN_RESET = 15'd16;

	typedef struct packed {
		logic [WIDTH_W-1:0] min_width;
		logic [WIDTH_W-1:0] index_margin;
		logic [TURN_W-1:0]  pulses_per_turn;
	} cfg_t;

	typedef struct packed {
		logic               rejected;
		logic               locked;
		logic [COUNT_W-1:0] position;
	} result_t;

endpackage

>>> src/ript_cfg.sv
module ript_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ript_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [ript_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ript_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output ript_pkg::cfg_t                      cfg
);

	ript_pkg::cfg_t cfg_q;
	logic [1:0]     reg_idx;
	logic           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width       <= '0;
			cfg_q.index_margin    <= '0;
			cfg_q.pulses_per_turn <= ript_pkg::PULSES_TURN_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				ript_pkg::REG_MIN_WIDTH:
					cfg_q.min_width <= pwdata[ript_pkg::WIDTH_W-1:0];
				ript_pkg::REG_INDEX_MARGIN:
					cfg_q.index_margin <= pwdata[ript_pkg::WIDTH_W-1:0];
				ript_pkg::REG_PULSES_TURN:
					cfg_q.pulses_per_turn <= pwdata[ript_pkg::TURN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			ript_pkg::REG_MIN_WIDTH:
				prdata[ript_pkg::WIDTH_W-1:0] = cfg_q.min_width;
			ript_pkg::REG_INDEX_MARGIN:
				prdata[ript_pkg::WIDTH_W-1:0] = cfg_q.index_margin;
			ript_pkg::REG_PULSES_TURN:
				prdata[ript_pkg::TURN_W-1:0] = cfg_q.pulses_per_turn;
			default: prdata = '0;
		endcase
	end

endmodule

>>> src/ript_core.sv
module ript_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [ript_pkg::WIDTH_W-1:0]     width,
	input  ript_pkg::cfg_t                   cfg,
	output ript_pkg::result_t                result
);

	logic [ript_pkg::WIDTH_W-1:0] hist_q [ript_pkg::HIST_DEPTH];
	logic                         sync_q;
	logic [ript_pkg::COUNT_W-1:0] count_q;

	logic                         rejected;
	logic                         index_hit;
	logic [ript_pkg::WIDTH_W:0]   oldest_sum;
	logic [ript_pkg::WIDTH_W:0]   newest_sum;
	logic [ript_pkg::COUNT_W-1:0] count_inc;
	logic                         past_turn;
	logic                         sync_d;
	logic [ript_pkg::COUNT_W-1:0] count_d;

	assign rejected = width < cfg.min_width;

	// window after the shift: oldest = hist[1], middle = hist[2], newest = width
	assign oldest_sum = {1'b0, hist_q[1]} + {1'b0, cfg.index_margin};
	assign newest_sum = {1'b0, width} + {1'b0, cfg.index_margin};
	assign index_hit  = (hist_q[1] >= cfg.min_width)
		&& ({1'b0, hist_q[2]} >= oldest_sum)
		&& ({1'b0, hist_q[2]} >= newest_sum);

	assign count_inc = count_q + 1'b1;
	assign past_turn = count_inc > {1'b0, cfg.pulses_per_turn};

	always_comb begin
		sync_d  = sync_q;
		count_d = count_q;
		if (!rejected) begin
			if (!sync_q) begin
				if (index_hit) begin
					sync_d  = 1'b1;
					count_d = ript_pkg::COUNT_W'(1);
				end
			end else begin
				count_d = count_inc;
				if (past_turn) begin
					if (index_hit) count_d = '0;
					else           sync_d  = 1'b0;   // late index
				end else if (index_hit) begin
					sync_d = 1'b0;                    // early index
				end
			end
		end
	end

	assign result.rejected = rejected;
	assign result.locked   = sync_d;
	assign result.position = count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ript_pkg::HIST_DEPTH; i++) hist_q[i] <= '0;
			sync_q  <= 1'b0;
			count_q <= '0;
		end else if (step) begin
			if (!rejected) begin
				for (int i = 0; i < ript_pkg::HIST_DEPTH - 1; i++) hist_q[i] <= hist_q[i+1];
				hist_q[ript_pkg::HIST_DEPTH-1] <= width;
			end
			sync_q  <= sync_d;
			count_q <= count_d;
		end
	end

endmodule

>>> src/rotor_index_position_tracker.sv
// Result path: an accepted pulse is held in the input register, then its result in the result register.
// Throughput: one pulse per cycle while the receiver takes results; tracker state updates in
// the cycle the registered pulse moves into the result register.
// Reset (arst_n low, asynchronous): history cleared, unlocked, position 0,
// registers to defaults (min_width 0, index_margin 0, pulses_per_turn 16).
module rotor_index_position_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ript_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [ript_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ript_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,   // [15:0] pulse_width
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata    // [15:0] position, [16] locked,
	                                                       // [17] rejected, [23:18] zero
);

	ript_pkg::cfg_t               cfg;
	ript_pkg::result_t            result;

	logic                         valid_s1;
	logic [ript_pkg::WIDTH_W-1:0] width_s1;
	logic                         valid_s2;
	ript_pkg::result_t            res_s2;
	logic                         advance;
	logic                         in_xfer;

	ript_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ript_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.width  (width_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) width_s1 <= s_tdata;
		if (advance) res_s2   <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.rejected, res_s2.locked, res_s2.position};

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty result register");

	a_xfer_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted pulse lost from input register");

	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result not captured on advance");

	a_position_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.locked) |-> (res_s2.position <= 16'd32768))
		else $error("locked position out of range");
`endif

endmodule

>>> verif/rotor_index_position_tracker_test.sv
module rotor_index_position_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 115;
	localparam int PHASE_COUNT  = 12;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            psel     = 1'b0;
	logic                            penable  = 1'b0;
	logic                            pwrite   = 1'b0;
	logic [ript_pkg::APB_ADDR_W-1:0] paddr    = '0;
	logic [ript_pkg::APB_DATA_W-1:0] pwdata   = '0;
	logic [ript_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [15:0]                     s_tdata  = '0;    // [15:0] pulse_width
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [23:0]                     m_tdata;   // [15:0] position, [16] locked, [17] rejected

	// tracker mirror
	ript_pkg::cfg_t    shadow_cfg = '{16'd0, 16'd0, ript_pkg::PULSES_TURN_RESET};
	logic [15:0]       pulse_hist [ript_pkg::HIST_DEPTH] = '{default: '0};
	logic              tracker_locked = 1'b0;
	logic [15:0]       tracker_count  = '0;
	ript_pkg::result_t expected_results [$];

	int error_count  = 0;
	int stall_cycles = 0;
	bit quiet        = 1'b0;
	bit hold_off_req = 1'b0;

	rotor_index_position_tracker uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// middle entry must clear both neighbors by the margin and the oldest must reach min_width; 17-bit sums never wrap
	function automatic logic index_in_history();
		logic [16:0] old_plus;
		logic [16:0] new_plus;
		old_plus = 17'(pulse_hist[0]) + 17'(shadow_cfg.index_margin);
		new_plus = 17'(pulse_hist[ript_pkg::HIST_DEPTH-1]) + 17'(shadow_cfg.index_margin);
		return pulse_hist[0] >= shadow_cfg.min_width &&
			17'(pulse_hist[1]) >= old_plus && 17'(pulse_hist[1]) >= new_plus;
	endfunction

	function automatic ript_pkg::result_t track_pulse(input logic [15:0] width);
		ript_pkg::result_t res;
		logic              hit;
		res.rejected = 1'b0;
		if (width < shadow_cfg.min_width) begin
			res.rejected = 1'b1;
		end else begin
			pulse_hist[0] = pulse_hist[1];
			pulse_hist[1] = pulse_hist[2];
			pulse_hist[2] = width;
			hit = index_in_history();
			if (!tracker_locked) begin
				if (hit) begin
					tracker_locked = 1'b1;
					tracker_count  = 16'd1;
				end
			end else begin
				tracker_count = tracker_count + 16'd1;
				if (tracker_count > {1'b0, shadow_cfg.pulses_per_turn}) begin
					if (hit)
						tracker_count = '0;
					else
						tracker_locked = 1'b0;    // late index
				end else if (hit) begin
					tracker_locked = 1'b0;        // early index
				end
			end
		end
		res.locked   = tracker_locked;
		res.position = tracker_count;
		return res;
	endfunction

	task automatic send_pulse(input logic [15:0] width);
		if (!quiet)
			while ($urandom_range(0, 99) < 14) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata  <= width;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(track_pulse(width));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_reg(input logic [1:0] idx);
		logic [ript_pkg::APB_DATA_W-1:0] got;
		logic [ript_pkg::APB_DATA_W-1:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			ript_pkg::REG_MIN_WIDTH:
				want = ript_pkg::APB_DATA_W'(shadow_cfg.min_width);
			ript_pkg::REG_INDEX_MARGIN:
				want = ript_pkg::APB_DATA_W'(shadow_cfg.index_margin);
			default:
				want = ript_pkg::APB_DATA_W'(shadow_cfg.pulses_per_turn);
		endcase
		if (got !== want) begin
			$error("prdata reg %0d: expected %0h, got %0h", idx, want, got);
			error_count++;
		end
		@(posedge clk);
	endtask

	task automatic program_reg(input logic [1:0] idx,
			input logic [ript_pkg::APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			ript_pkg::REG_MIN_WIDTH:
				shadow_cfg.min_width = value[ript_pkg::WIDTH_W-1:0];
			ript_pkg::REG_INDEX_MARGIN:
				shadow_cfg.index_margin = value[ript_pkg::WIDTH_W-1:0];
			default:
				shadow_cfg.pulses_per_turn = value[ript_pkg::TURN_W-1:0];
		endcase
		@(posedge clk);
		check_reg(idx);
	endtask

	task automatic set_config(input logic [31:0] minw, input logic [31:0] margin,
			input logic [31:0] turn);
		program_reg(ript_pkg::REG_MIN_WIDTH, minw);
		program_reg(ript_pkg::REG_INDEX_MARGIN, margin);
		program_reg(ript_pkg::REG_PULSES_TURN, turn);
	endtask

	// defaults lock on an all-zero history; the third pulse is an early index
	task automatic test_reset_values();
		check_reg(ript_pkg::REG_MIN_WIDTH);
		check_reg(ript_pkg::REG_INDEX_MARGIN);
		check_reg(ript_pkg::REG_PULSES_TURN);
		send_pulse(16'h0000);
		send_pulse(16'hFFFF);
		send_pulse(16'h0000);
		wait_drained();
	endtask

	// noise, lock, rezero at the end of a turn, then a late index
	task automatic test_noise_and_lock();
		set_config(32'd100, 32'd50, 32'd2);
		send_pulse(16'd99);
		send_pulse(16'd100);
		send_pulse(16'd300);
		send_pulse(16'd100);
		send_pulse(16'd300);
		send_pulse(16'd100);
		send_pulse(16'd99);
		send_pulse(16'd100);
		send_pulse(16'd100);
		send_pulse(16'd100);
		wait_drained();
	endtask

	task automatic test_field_extremes();
		// upper write bits are dropped by the register widths
		program_reg(ript_pkg::REG_MIN_WIDTH, 32'hABCD_FFFF);
		send_pulse(16'hFFFE);
		send_pulse(16'hFFFF);
		wait_drained();
		// full margin, out-of-range zero turn length
		set_config(32'd0, 32'h0000_FFFF, 32'h0000_8000);
		send_pulse(16'h0001);
		send_pulse(16'hFFFF);
		send_pulse(16'h0000);
		send_pulse(16'hFFFF);
		send_pulse(16'h0000);
		wait_drained();
		// margin dropped while locked: once the window holds equal widths, they index on every pulse
		program_reg(ript_pkg::REG_INDEX_MARGIN, 32'd0);
		send_pulse(16'd7);
		send_pulse(16'd7);
		send_pulse(16'd7);
		send_pulse(16'd7);
		wait_drained();
	endtask

	task automatic test_backpressure();
		set_config(32'd0, 32'd2, 32'd3);
		hold_off_req = 1'b1;
		repeat (40) send_pulse(16'($urandom_range(0, 7)));
		wait_drained();
	endtask

	task automatic test_rotation_phases();
		logic [15:0] minw;
		logic [15:0] margin;
		logic [15:0] base;
		logic [14:0] turn;
		logic [15:0] width;
		bit          last_index;
		bit          index_due;
		int          r;
		int          k;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			quiet = (p == 0);
			if (p % 4 == 3) begin
				k = p / 4;
				case (k)
					0:       set_config(32'd0, 32'd0, 32'd1);
					1:       set_config(32'd0, 32'h0000_FFFF, 32'd32767);
					default: set_config($urandom_range(0, 7), $urandom_range(0, 3), 32'h0000_8000);
				endcase
				repeat (PHASE_ITEMS) begin
					r = $urandom_range(0, 9);
					if (r == 0)
						width = 16'h0000;
					else if (r == 1)
						width = 16'hFFFF;
					else if (r < 7)
						width = 16'($urandom_range(0, 7));
					else
						width = 16'($urandom);
					send_pulse(width);
				end
			end else begin
				minw   = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 2000));
				margin = 16'($urandom_range(1, 3000));
				base   = minw + 16'($urandom_range(0, 5000));
				turn   = 15'($urandom_range(1, 12));
				set_config(32'(minw), 32'(margin), 32'(turn));
				last_index = 1'b0;
				repeat (PHASE_ITEMS) begin
					r = $urandom_range(0, 99);
					index_due = tracker_locked ? (int'(tracker_count) + 1 >= int'(turn))
						: (r < 32);
					if (minw != 0 && r < 6) begin
						width = 16'($urandom_range(0, minw - 1));
					end else if (r < 9) begin
						width      = 16'($urandom);
						last_index = 1'b0;
					end else if (!last_index && (r < 12 || (r >= 15 && index_due))) begin
						width      = 16'(base + 2 * margin + 16'($urandom_range(0, 2000)));
						last_index = 1'b1;
					end else begin
						// also covers a missing index when one was due
						width      = base + 16'($urandom_range(0, margin - 1));
						last_index = 1'b0;
					end
					send_pulse(width);
				end
			end
			wait_drained();
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_noise_and_lock();
		test_field_extremes();
		test_backpressure();
		test_rotation_phases();
		if (error_count == 0)
			$display("rotor_index_position_tracker test passed");
		else
			$display("rotor_index_position_tracker test failed");
		$finish;
	end

	// result receiver: random stalls, a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	always @(posedge clk) begin : check_results
		ript_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[15:0] !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, m_tdata[15:0]);
					error_count++;
				end
				if (m_tdata[16] !== want.locked) begin
					$error("locked: expected %0b, got %0b", want.locked, m_tdata[16]);
					error_count++;
				end
				if (m_tdata[17] !== want.rejected) begin
					$error("rejected: expected %0b, got %0b", want.rejected, m_tdata[17]);
					error_count++;
				end
				if (m_tdata[23:18] !== 6'd0) begin
					$error("pad: expected 0, got %0h", m_tdata[23:18]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("rotor_index_position_tracker test failed");
				$finish;
			end
		end
	end

endmodule
